// File: sv/siq_pkg.sv
// Shared types, codes and defaults for the sorted insert request queue.
package siq_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int KeyBitsDefault    = 31;
   localparam int TagBitsDefault    = 16;

   typedef enum logic [1:0] {
      FUNC_PUSH_TAIL   = 2'd0,
      FUNC_PUSH_SORTED = 2'd1,
      FUNC_POP         = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Operation broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic push_en;
      logic sorted;
      logic pop_en;
   } ctrl_type;

endpackage

// File: sv/siq_cell.sv
// One storage cell of the queue chain: holds a single entry and trades with its neighbors.
module siq_cell
   import siq_pkg::*;
#(
   parameter int KEY_BITS = KeyBitsDefault,
   parameter int TAG_BITS = TagBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic                left_valid,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [TAG_BITS-1:0] left_tag,
   input  logic                left_before,
   input  logic                right_valid,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [TAG_BITS-1:0] right_tag,
   output logic                valid,
   output logic [KEY_BITS-1:0] key,
   output logic [TAG_BITS-1:0] tag,
   output logic                insert_mark
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                hit;

   // The new entry belongs in front of this cell when its key is strictly smaller.
   assign hit         = valid_ff && ctrl.sorted && (new_key < key_ff);
   assign insert_mark = hit || left_before;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctrl.push_en) begin
         if (left_before) begin
            // Insertion point lies to the left: shift one place toward the tail.
            valid_in = left_valid;
            key_in   = left_key;
            tag_in   = left_tag;
         end else if (hit || (!valid_ff && left_valid)) begin
            valid_in = 1'b1;
            key_in   = new_key;
            tag_in   = new_tag;
         end
      end else if (ctrl.pop_en) begin
         valid_in = right_valid;
         key_in   = right_key;
         tag_in   = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign tag   = tag_ff;

endmodule

// File: sv/sorted_insert_request_queue.sv
// Top level of the sorted insert request queue: a chain of entry cells and the response register.
// Latency: the response beat appears in the cycle after start is taken, as a one-cycle strobe.
// Throughput: one request per cycle; every cell compares and shifts in the same cycle.
// busy is never raised, and the receiver cannot stall the response channel.
// Reset clears every cell's valid bit at once; stored keys and tags are not cleared.
// The queue is usable in the first cycle after reset is released.
module sorted_insert_request_queue
   import siq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int KEY_BITS    = KeyBitsDefault,
   parameter int TAG_BITS    = TagBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic [TAG_BITS-1:0] req_item_tag,
   input  logic [KEY_BITS-1:0] req_item_key,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_head_valid,
   output logic [TAG_BITS-1:0] rsp_head_tag,
   output logic [KEY_BITS-1:0] rsp_head_key,
   output logic [TAG_BITS-1:0] rsp_popped_tag
);

   // Per-cell views of the chain. Index 0 is the head of the queue; valid
   // entries always form an unbroken run starting at the head.
   logic                cell_valid  [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] cell_key    [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag    [QUEUE_DEPTH];
   logic                cell_before [QUEUE_DEPTH];

   logic       accept;
   logic       queue_full;
   logic       queue_empty;
   ctrl_type   ctrl;
   status_type status_in;

   logic                rsp_valid_ff;
   status_type          status_ff;
   logic [TAG_BITS-1:0] popped_ff, popped_in;

   // Every request is finished in the cycle it is taken, so the block never holds start off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // The tail cell is occupied exactly when the queue is full, and the head
   // cell is empty exactly when the queue is empty.
   assign queue_full  = cell_valid[QUEUE_DEPTH-1];
   assign queue_empty = !cell_valid[0];

   // Decode the request into the broadcast that every cell sees. A push into a
   // full queue and a pop from an empty one leave the cells alone; the unused
   // operation code does nothing and reports ok.
   always_comb begin
      ctrl      = '0;
      status_in = STATUS_OK;
      popped_in = '0;
      case (func_type'(req_func))
         FUNC_PUSH_TAIL: begin
            if (queue_full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.push_en = accept;
            end
         end
         FUNC_PUSH_SORTED: begin
            ctrl.sorted = 1'b1;
            if (queue_full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.push_en = accept;
            end
         end
         FUNC_POP: begin
            if (queue_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctrl.pop_en = accept;
               popped_in   = cell_tag[0];
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // The chain. Each cell sees its left neighbor (for a shift toward the tail
   // on a push) and its right neighbor (for a shift toward the head on a pop).
   // The insertion mark ripples from head to tail so that a sorted push lands in
   // front of the first stored entry with a strictly greater key, even when
   // earlier plain pushes left the keys out of order.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                left_valid;
      logic [KEY_BITS-1:0] left_key;
      logic [TAG_BITS-1:0] left_tag;
      logic                left_before;
      logic                right_valid;
      logic [KEY_BITS-1:0] right_key;
      logic [TAG_BITS-1:0] right_tag;

      if (i == 0) begin : g_head
         // The head may always take the new entry when it is empty.
         assign left_valid  = 1'b1;
         assign left_key    = '0;
         assign left_tag    = '0;
         assign left_before = 1'b0;
      end else begin : g_inner_left
         assign left_valid  = cell_valid[i-1];
         assign left_key    = cell_key[i-1];
         assign left_tag    = cell_tag[i-1];
         assign left_before = cell_before[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_key   = '0;
         assign right_tag   = '0;
      end else begin : g_inner_right
         assign right_valid = cell_valid[i+1];
         assign right_key   = cell_key[i+1];
         assign right_tag   = cell_tag[i+1];
      end

      siq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_key     (req_item_key),
         .new_tag     (req_item_tag),
         .left_valid  (left_valid),
         .left_key    (left_key),
         .left_tag    (left_tag),
         .left_before (left_before),
         .right_valid (right_valid),
         .right_key   (right_key),
         .right_tag   (right_tag),
         .valid       (cell_valid[i]),
         .key         (cell_key[i]),
         .tag         (cell_tag[i]),
         .insert_mark (cell_before[i])
      );
   end

   // Response register. Status and popped tag are captured with the request;
   // the head fields come straight from the head cell, which already holds the
   // state after the operation during the strobe cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_popped_tag = popped_ff;
   assign rsp_head_valid = cell_valid[0];
   assign rsp_head_tag   = cell_valid[0] ? cell_tag[0] : '0;
   assign rsp_head_key   = cell_valid[0] ? cell_key[0] : '0;

endmodule

// File: sv/siq_checker.sv
// Port-level assertions for the sorted insert request queue, bound to the top level.
module siq_checker
   import siq_pkg::*;
#(
   parameter int KEY_BITS = KeyBitsDefault,
   parameter int TAG_BITS = TagBitsDefault
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [1:0]          req_func,
   input logic                rsp_valid,
   input logic [1:0]          rsp_status,
   input logic                rsp_head_valid,
   input logic [TAG_BITS-1:0] rsp_head_tag,
   input logic [KEY_BITS-1:0] rsp_head_key,
   input logic [TAG_BITS-1:0] rsp_popped_tag
);

   // Exactly one response beat follows each accepted request, in the next cycle.
   a_one_beat_per_request: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted request produced no response beat");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response beat without an accepted request");

   // An empty queue reports a zero head.
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_head_valid) |-> (rsp_head_tag == '0 && rsp_head_key == '0))
      else $error("empty queue reported a nonzero head");

   // A dropped push leaves a full, hence nonempty, queue; a failed pop an empty one.
   a_status_vs_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != STATUS_FULL || rsp_head_valid) &&
                     (rsp_status != STATUS_EMPTY || !rsp_head_valid)))
      else $error("status disagrees with the head indication");

   // A removed tag is only reported for a successful pop.
   a_popped_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_popped_tag != '0) |->
         ($past(req_func) == FUNC_POP && rsp_status == STATUS_OK))
      else $error("popped tag reported for something other than a successful pop");

endmodule

bind sorted_insert_request_queue siq_checker #(
   .KEY_BITS (KEY_BITS),
   .TAG_BITS (TAG_BITS)
) u_siq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_head_valid (rsp_head_valid),
   .rsp_head_tag   (rsp_head_tag),
   .rsp_head_key   (rsp_head_key),
   .rsp_popped_tag (rsp_popped_tag)
);
